FILE: rtl/core/llsf_pkg.sv
// Shared constants, codes and types of the least-squares line fit block.
package llsf_pkg;

  // Fixed design constants
  localparam int MAX_POINTS    = 1024;
  localparam int SAMPLE_BITS   = 16;
  localparam int FRAC_BITS     = 16;
  localparam int FEWEST_POINTS = 3;

  // Port field widths
  localparam int FIELD_W  = 16;
  localparam int RESULT_W = 64;
  localparam int STATUS_W = 2;
  localparam int USED_W   = 11;

  // Accumulator and datapath widths
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int SUM_W      = SAMPLE_BITS + $clog2(MAX_POINTS);
  localparam int XY_W       = 2 * SAMPLE_BITS + $clog2(MAX_POINTS);
  localparam int PP_W       = 2 * SAMPLE_BITS;
  localparam int MAG_A_W    = XY_W - 1;
  localparam int CHUNK_W    = (SUM_W + 1) / 2;
  localparam int PROD_MAG_W = MAG_A_W + SUM_W;
  localparam int PROD_W     = PROD_MAG_W + 1;
  localparam int NUM_W      = PROD_W + FRAC_BITS;
  localparam int DEN_W      = PROD_W - 1;
  localparam int DIV_CNT_W  = $clog2(NUM_W + 1);

  // Product schedule of the fit: six products, index 0 to MUL_LAST
  localparam int MUL_IDX_W = 3;
  localparam logic [MUL_IDX_W-1:0] MUL_N_SXX  = 3'd0;
  localparam logic [MUL_IDX_W-1:0] MUL_SX_SX  = 3'd1;
  localparam logic [MUL_IDX_W-1:0] MUL_N_SXY  = 3'd2;
  localparam logic [MUL_IDX_W-1:0] MUL_SY_SX  = 3'd3;
  localparam logic [MUL_IDX_W-1:0] MUL_SXX_SY = 3'd4;
  localparam logic [MUL_IDX_W-1:0] MUL_SXY_SX = 3'd5;
  localparam logic [MUL_IDX_W-1:0] MUL_LAST   = MUL_SXY_SX;

  // Status codes
  localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FEW  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FLAT = 2'd2;

  // Classified point as it travels from front to back
  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] x;
    logic signed [SAMPLE_BITS-1:0] y;
    logic                          last;
    logic                          keep;
  } llsf_item_t;

  typedef struct packed {
    logic                    start;
    logic signed [XY_W-1:0]  a;
    logic signed [SUM_W-1:0] b;
  } llsf_mul_req_t;

  typedef struct packed {
    logic                     done;
    logic signed [PROD_W-1:0] prod;
  } llsf_mul_rsp_t;

  typedef struct packed {
    logic                    start;
    logic signed [NUM_W-1:0] num;
    logic [DEN_W-1:0]        den;
  } llsf_div_req_t;

  typedef struct packed {
    logic                       done;
    logic signed [RESULT_W-1:0] quot;
  } llsf_div_rsp_t;

endpackage

FILE: rtl/core/llsf_if.sv
// Valid/ready channel interfaces for points in and fit results out.
interface llsf_in_if import llsf_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [FIELD_W-1:0]  x_value;
  logic signed [FIELD_W-1:0]  y_value;
  logic                       last_point;

  modport source (output valid, x_value, y_value, last_point, input ready);
  modport sink   (input valid, x_value, y_value, last_point, output ready);
endinterface

interface llsf_out_if import llsf_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [RESULT_W-1:0] slope;
  logic signed [RESULT_W-1:0] intercept;
  logic [STATUS_W-1:0]        status;
  logic [USED_W-1:0]          points_used;
  logic                       truncated;

  modport source (output valid, slope, intercept, status, points_used, truncated,
                  input ready);
  modport sink   (input valid, slope, intercept, status, points_used, truncated,
                  output ready);
endinterface

FILE: rtl/core/llsf_front.sv
// Front end: accepts points, checks capacity and tags each beat keep or drop.
module llsf_front import llsf_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  llsf_in_if.sink      in_ch,
  output llsf_item_t   fr_item,
  output logic         fr_valid,
  input  logic         fr_ready
);

  logic             valid_r;
  llsf_item_t       item_r;
  logic [CNT_W-1:0] count_r;
  logic             accept;
  logic             keep;

  assign in_ch.ready = !valid_r || fr_ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign keep        = count_r < CNT_W'(MAX_POINTS);

  assign fr_item  = item_r;
  assign fr_valid = valid_r;

  // Hold the classified beat until the queue takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (accept) begin
      valid_r <= 1'b1;
    end else if (fr_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r.x    <= in_ch.x_value[SAMPLE_BITS-1:0];
      item_r.y    <= in_ch.y_value[SAMPLE_BITS-1:0];
      item_r.last <= in_ch.last_point;
      item_r.keep <= keep;
    end
  end

  // Track points admitted in the current set; restart after the last point
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (accept) begin
      if (in_ch.last_point) begin
        count_r <= '0;
      end else if (keep) begin
        count_r <= count_r + 1'b1;
      end
    end
  end

endmodule

FILE: rtl/core/llsf_queue.sv
// Two-entry queue that decouples the front end from the back end.
module llsf_queue import llsf_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push_valid,
  output logic       push_ready,
  input  llsf_item_t push_item,
  output logic       pop_valid,
  input  logic       pop_ready,
  output llsf_item_t pop_item
);

  llsf_item_t  mem_r [2];
  logic        wr_ptr_r;
  logic        rd_ptr_r;
  logic [1:0]  cnt_r;
  logic        push;
  logic        pop;

  assign push_ready = cnt_r != 2'd2;
  assign pop_valid  = cnt_r != 2'd0;
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_item   = mem_r[rd_ptr_r];

  // Write the incoming beat
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

endmodule

FILE: rtl/core/llsf_mul.sv
// Sequential signed multiplier: wide operand times narrow one, two chunks.
module llsf_mul import llsf_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  llsf_mul_req_t req,
  output llsf_mul_rsp_t rsp
);

  logic                    busy_r;
  logic [1:0]              step_r;
  logic                    neg_r;
  logic [MAG_A_W-1:0]      ma_r;
  logic [SUM_W-1:0]        mb_r;
  logic [PROD_MAG_W-1:0]   acc_r;
  logic signed [PROD_W-1:0] prod_r;
  logic                    done_r;

  logic [XY_W-1:0]         a_abs;
  logic [SUM_W-1:0]        b_abs;
  logic [CHUNK_W-1:0]      chunk;
  logic [PROD_MAG_W-1:0]   pp;
  logic [PROD_W-1:0]       mag;

  assign a_abs = req.a[XY_W-1] ? (~req.a + 1'b1) : req.a;
  assign b_abs = req.b[SUM_W-1] ? (~req.b + 1'b1) : req.b;

  // High chunk first, then low chunk
  assign chunk = (step_r == 2'd0) ? CHUNK_W'(mb_r[SUM_W-1:CHUNK_W])
                                  : mb_r[CHUNK_W-1:0];
  assign pp    = ma_r * chunk;
  assign mag   = {1'b0, acc_r};

  assign rsp.done = done_r;
  assign rsp.prod = prod_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= 2'd0;
    end else begin
      done_r <= 1'b0;
      if (!busy_r) begin
        if (req.start) begin
          busy_r <= 1'b1;
          step_r <= 2'd0;
        end
      end else begin
        step_r <= step_r + 2'd1;
        if (step_r == 2'd2) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Load magnitudes, accumulate partial products, apply sign
  always_ff @(posedge clk) begin
    if (!busy_r && req.start) begin
      neg_r <= req.a[XY_W-1] ^ req.b[SUM_W-1];
      ma_r  <= a_abs[MAG_A_W-1:0];
      mb_r  <= b_abs;
    end
    if (busy_r) begin
      case (step_r)
        2'd0:    acc_r <= pp;
        2'd1:    acc_r <= (acc_r << CHUNK_W) + pp;
        default: prod_r <= neg_r ? (~mag + 1'b1) : mag;
      endcase
    end
  end

endmodule

FILE: rtl/core/llsf_div.sv
// Restoring divider: signed numerator over positive denominator, saturated.
module llsf_div import llsf_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  llsf_div_req_t req,
  output llsf_div_rsp_t rsp
);

  logic                       busy_r;
  logic                       done_r;
  logic [DIV_CNT_W-1:0]       cnt_r;
  logic                       neg_r;
  logic [NUM_W-1:0]           num_r;
  logic [NUM_W-1:0]           quo_r;
  logic [DEN_W-1:0]           den_r;
  logic [DEN_W-1:0]           rem_r;
  logic signed [RESULT_W-1:0] quot_r;

  logic [NUM_W-1:0]           num_abs;
  logic [DEN_W:0]             rem_sh;
  logic [DEN_W:0]             diff;
  logic                       ge;
  logic                       hi_zero;
  logic [RESULT_W-1:0]        sat;

  assign num_abs = req.num[NUM_W-1] ? (~req.num + 1'b1) : req.num;

  // One quotient bit per cycle
  assign rem_sh = {rem_r, num_r[NUM_W-1]};
  assign diff   = rem_sh - {1'b0, den_r};
  assign ge     = rem_sh >= {1'b0, den_r};

  // Saturate the magnitude to the signed result range
  assign hi_zero = ~|quo_r[NUM_W-1:RESULT_W];
  always_comb begin
    if (neg_r) begin
      if (hi_zero && (!quo_r[RESULT_W-1] || ~|quo_r[RESULT_W-2:0])) begin
        sat = ~quo_r[RESULT_W-1:0] + 1'b1;
      end else begin
        sat = {1'b1, {(RESULT_W-1){1'b0}}};
      end
    end else begin
      if (hi_zero && !quo_r[RESULT_W-1]) begin
        sat = quo_r[RESULT_W-1:0];
      end else begin
        sat = {1'b0, {(RESULT_W-1){1'b1}}};
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = quot_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (!busy_r) begin
        if (req.start) begin
          busy_r <= 1'b1;
          cnt_r  <= DIV_CNT_W'(NUM_W);
        end
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - 1'b1;
      end else begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!busy_r && req.start) begin
      neg_r <= req.num[NUM_W-1];
      num_r <= num_abs;
      den_r <= req.den;
      rem_r <= '0;
      quo_r <= '0;
    end else if (busy_r) begin
      if (cnt_r != '0) begin
        rem_r <= ge ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
        quo_r <= {quo_r[NUM_W-2:0], ge};
        num_r <= num_r << 1;
      end else begin
        quot_r <= sat;
      end
    end
  end

endmodule

FILE: rtl/core/llsf_back.sv
// Back end: accumulates sums, runs the fit sequence and holds the result beat.
module llsf_back import llsf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  output logic        q_ready,
  input  llsf_item_t  q_item,
  llsf_out_if.source  out_ch
);

  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_ACC_SQ   = 4'd1;
  localparam logic [3:0] ST_ACC_XY   = 4'd2;
  localparam logic [3:0] ST_FIT      = 4'd3;
  localparam logic [3:0] ST_MUL_GO   = 4'd4;
  localparam logic [3:0] ST_MUL_WAIT = 4'd5;
  localparam logic [3:0] ST_CHECK    = 4'd6;
  localparam logic [3:0] ST_DIVS_GO  = 4'd7;
  localparam logic [3:0] ST_DIVS_WT  = 4'd8;
  localparam logic [3:0] ST_DIVI_GO  = 4'd9;
  localparam logic [3:0] ST_DIVI_WT  = 4'd10;
  localparam logic [3:0] ST_OUT      = 4'd11;

  logic [3:0]                    state_r;
  logic [3:0]                    state_nxt;

  logic signed [SAMPLE_BITS-1:0] x_r;
  logic signed [SAMPLE_BITS-1:0] y_r;
  logic                          last_r;
  logic [CNT_W-1:0]              n_r;
  logic signed [SUM_W-1:0]       sx_r;
  logic signed [SUM_W-1:0]       sy_r;
  logic signed [XY_W-1:0]        sxx_r;
  logic signed [XY_W-1:0]        sxy_r;
  logic                          ovf_r;
  logic [MUL_IDX_W-1:0]          mul_idx_r;
  logic signed [PROD_W-1:0]      den_r;
  logic signed [PROD_W-1:0]      ns_r;
  logic signed [PROD_W-1:0]      ni_r;
  logic signed [RESULT_W-1:0]    slope_r;
  logic signed [RESULT_W-1:0]    icpt_r;
  logic [STATUS_W-1:0]           status_r;

  logic                          out_valid_r;
  logic signed [RESULT_W-1:0]    out_slope_r;
  logic signed [RESULT_W-1:0]    out_icpt_r;
  logic [STATUS_W-1:0]           out_status_r;
  logic [USED_W-1:0]             out_used_r;
  logic                          out_trunc_r;

  logic signed [SAMPLE_BITS-1:0] pm_b;
  logic signed [PP_W-1:0]        pp;
  logic                          out_free;
  logic signed [NUM_W-1:0]       ns_ext;
  logic signed [NUM_W-1:0]       ni_ext;
  llsf_mul_req_t                 mul_req;
  llsf_mul_rsp_t                 mul_rsp;
  llsf_div_req_t                 div_req;
  llsf_div_rsp_t                 div_rsp;

  llsf_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req),
    .rsp   (mul_rsp)
  );

  llsf_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign q_ready  = state_r == ST_IDLE;
  assign out_free = !out_valid_r || out_ch.ready;

  // Shared point multiplier: x*x first, then x*y
  assign pm_b = (state_r == ST_ACC_XY) ? y_r : x_r;
  assign pp   = x_r * pm_b;

  // Operand pairs of the six fit products
  always_comb begin
    mul_req.start = state_r == ST_MUL_GO;
    case (mul_idx_r)
      MUL_N_SXX: begin
        mul_req.a = sxx_r;
        mul_req.b = {{(SUM_W-CNT_W){1'b0}}, n_r};
      end
      MUL_SX_SX: begin
        mul_req.a = XY_W'(sx_r);
        mul_req.b = sx_r;
      end
      MUL_N_SXY: begin
        mul_req.a = sxy_r;
        mul_req.b = {{(SUM_W-CNT_W){1'b0}}, n_r};
      end
      MUL_SY_SX: begin
        mul_req.a = XY_W'(sy_r);
        mul_req.b = sx_r;
      end
      MUL_SXX_SY: begin
        mul_req.a = sxx_r;
        mul_req.b = sy_r;
      end
      MUL_SXY_SX: begin
        mul_req.a = sxy_r;
        mul_req.b = sx_r;
      end
      default: begin
        mul_req.a = '0;
        mul_req.b = '0;
      end
    endcase
  end

  // Scale numerators by the fraction bits before dividing
  assign ns_ext = NUM_W'(ns_r) <<< FRAC_BITS;
  assign ni_ext = NUM_W'(ni_r) <<< FRAC_BITS;

  assign div_req.start = (state_r == ST_DIVS_GO) || (state_r == ST_DIVI_GO);
  assign div_req.num   = (state_r == ST_DIVS_GO) ? ns_ext : ni_ext;
  assign div_req.den   = den_r[DEN_W-1:0];

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          if (q_item.keep) begin
            state_nxt = ST_ACC_SQ;
          end else if (q_item.last) begin
            state_nxt = ST_FIT;
          end
        end
      end
      ST_ACC_SQ: state_nxt = ST_ACC_XY;
      ST_ACC_XY: state_nxt = last_r ? ST_FIT : ST_IDLE;
      ST_FIT: begin
        state_nxt = (n_r < CNT_W'(FEWEST_POINTS)) ? ST_OUT : ST_MUL_GO;
      end
      ST_MUL_GO: state_nxt = ST_MUL_WAIT;
      ST_MUL_WAIT: begin
        if (mul_rsp.done) begin
          state_nxt = (mul_idx_r == MUL_LAST) ? ST_CHECK : ST_MUL_GO;
        end
      end
      ST_CHECK: state_nxt = (den_r <= 0) ? ST_OUT : ST_DIVS_GO;
      ST_DIVS_GO: state_nxt = ST_DIVS_WT;
      ST_DIVS_WT: begin
        if (div_rsp.done) begin
          state_nxt = ST_DIVI_GO;
        end
      end
      ST_DIVI_GO: state_nxt = ST_DIVI_WT;
      ST_DIVI_WT: begin
        if (div_rsp.done) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Running sums, count and capacity flag; clear once the result beat is loaded
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r   <= '0;
      sx_r  <= '0;
      sy_r  <= '0;
      sxx_r <= '0;
      sxy_r <= '0;
      ovf_r <= 1'b0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (q_valid && !q_item.keep) begin
            ovf_r <= 1'b1;
          end
        end
        ST_ACC_SQ: begin
          sx_r  <= sx_r + SUM_W'(x_r);
          sy_r  <= sy_r + SUM_W'(y_r);
          sxx_r <= sxx_r + XY_W'(pp);
          n_r   <= n_r + 1'b1;
        end
        ST_ACC_XY: begin
          sxy_r <= sxy_r + XY_W'(pp);
        end
        ST_OUT: begin
          if (out_free) begin
            n_r   <= '0;
            sx_r  <= '0;
            sy_r  <= '0;
            sxx_r <= '0;
            sxy_r <= '0;
            ovf_r <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Fit datapath: latch the point, gather products, collect quotients
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          x_r    <= q_item.x;
          y_r    <= q_item.y;
          last_r <= q_item.last;
        end
      end
      ST_FIT: begin
        mul_idx_r <= MUL_N_SXX;
        slope_r   <= '0;
        icpt_r    <= '0;
        status_r  <= (n_r < CNT_W'(FEWEST_POINTS)) ? STATUS_FEW : STATUS_OK;
      end
      ST_MUL_WAIT: begin
        if (mul_rsp.done) begin
          mul_idx_r <= mul_idx_r + 1'b1;
          case (mul_idx_r)
            MUL_N_SXX:  den_r <= mul_rsp.prod;
            MUL_SX_SX:  den_r <= den_r - mul_rsp.prod;
            MUL_N_SXY:  ns_r  <= mul_rsp.prod;
            MUL_SY_SX:  ns_r  <= ns_r - mul_rsp.prod;
            MUL_SXX_SY: ni_r  <= mul_rsp.prod;
            MUL_SXY_SX: ni_r  <= ni_r - mul_rsp.prod;
            default: begin
            end
          endcase
        end
      end
      ST_CHECK: begin
        if (den_r <= 0) begin
          status_r <= STATUS_FLAT;
        end
      end
      ST_DIVS_WT: begin
        if (div_rsp.done) begin
          slope_r <= div_rsp.quot;
        end
      end
      ST_DIVI_WT: begin
        if (div_rsp.done) begin
          icpt_r <= div_rsp.quot;
        end
      end
      default: begin
      end
    endcase
  end

  // Output register: load the result beat, drop valid once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_OUT && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_OUT && out_free) begin
      out_slope_r  <= slope_r;
      out_icpt_r   <= icpt_r;
      out_status_r <= status_r;
      out_used_r   <= USED_W'(n_r);
      out_trunc_r  <= ovf_r;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.slope       = out_slope_r;
  assign out_ch.intercept   = out_icpt_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.points_used = out_used_r;
  assign out_ch.truncated   = out_trunc_r;

endmodule

FILE: rtl/core/linear_least_squares_fit.sv
// Least-squares straight-line fit over a stream of signed points. In the back
// end each point is taken from the queue, then x*x and x*y are formed through
// one 16x16 multiplier. A point beyond capacity (1024 held) is dropped and
// sets the truncated flag. A two-entry queue sits between the input stage and
// the back end, so points keep flowing in while the back end works. On the
// point marked last of a set of three or more, the back end forms six wide
// products on a two-chunk sequential multiplier. It then runs two restoring
// divisions of one quotient bit per cycle (84 bits each), unless the
// denominator is zero. Slope and intercept carry 16 fraction bits, truncated
// toward zero and saturated to 64 bits. Status reports fewer than three points
// or a zero denominator; sums clear once the result beat is loaded into the
// output register.
module linear_least_squares_fit import llsf_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  llsf_in_if.sink    in_ch,
  llsf_out_if.source out_ch
);

  llsf_item_t fr_item;
  logic       fr_valid;
  logic       fr_ready;
  llsf_item_t q_item;
  logic       q_valid;
  logic       q_ready;

  llsf_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .fr_item  (fr_item),
    .fr_valid (fr_valid),
    .fr_ready (fr_ready)
  );

  llsf_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fr_valid),
    .push_ready (fr_ready),
    .push_item  (fr_item),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_item   (q_item)
  );

  llsf_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_item  (q_item),
    .out_ch  (out_ch)
  );

endmodule

FILE: sim/llsf_fit_checker.sv
// Line-fit checker: watches both channels, predicts each fit result and compares it.
module llsf_fit_checker import llsf_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  llsf_in_if   in_mon,
  llsf_out_if  out_mon,
  output int   fit_errors,
  output int   fits_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic signed [127:0] POS_LIMIT = 128'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [127:0] NEG_LIMIT = -128'sh8000_0000_0000_0000;

  typedef struct packed {
    logic signed [RESULT_W-1:0] slope;
    logic signed [RESULT_W-1:0] intercept;
    logic [STATUS_W-1:0]        status;
    logic [USED_W-1:0]          points_used;
    logic                       truncated;
  } line_fit_t;

  // Running sums of the open data set, kept exactly
  int        held;
  longint    sum_x;
  longint    sum_y;
  longint    sum_xx;
  longint    sum_xy;
  logic      overflowed;
  line_fit_t fit_q[$];

  // Scaled quotient, truncated toward zero and clamped to 64 bits
  function automatic logic signed [RESULT_W-1:0] scaled_ratio(
    input logic signed [127:0] num,
    input logic signed [127:0] den
  );
    logic signed [127:0] q;
    q = num / den;
    if (q > POS_LIMIT) return POS_LIMIT[RESULT_W-1:0];
    if (q < NEG_LIMIT) return NEG_LIMIT[RESULT_W-1:0];
    return q[RESULT_W-1:0];
  endfunction

  // Close the open data set into one expected result
  function automatic line_fit_t fit_held_points();
    line_fit_t           r;
    logic signed [127:0] n, sx, sy, sxx, sxy, den;
    n   = held;
    sx  = sum_x;
    sy  = sum_y;
    sxx = sum_xx;
    sxy = sum_xy;
    den = n * sxx - sx * sx;
    r.slope       = '0;
    r.intercept   = '0;
    r.status      = STATUS_OK;
    r.points_used = held[USED_W-1:0];
    r.truncated   = overflowed;
    if (held < FEWEST_POINTS) begin
      r.status = STATUS_FEW;
    end else if (den <= 0) begin
      r.status = STATUS_FLAT;
    end else begin
      r.slope     = scaled_ratio((n * sxy - sx * sy) <<< FRAC_BITS, den);
      r.intercept = scaled_ratio((sxx * sy - sx * sxy) <<< FRAC_BITS, den);
    end
    return r;
  endfunction

  task automatic clear_sums();
    held       = 0;
    sum_x      = 0;
    sum_y      = 0;
    sum_xx     = 0;
    sum_xy     = 0;
    overflowed = 1'b0;
  endtask

  // Accumulate one point; a point past capacity only marks the set
  task automatic take_point(
    input logic signed [FIELD_W-1:0] x,
    input logic signed [FIELD_W-1:0] y,
    input logic                      last
  );
    longint xs, ys;
    xs = x;
    ys = y;
    if (held < MAX_POINTS) begin
      sum_x  += xs;
      sum_y  += ys;
      sum_xx += xs * xs;
      sum_xy += xs * ys;
      held++;
    end else begin
      overflowed = 1'b1;
    end
    if (last) begin
      fit_q.insert(fit_q.size(), fit_held_points());
      clear_sums();
    end
  endtask

  task automatic flag_field(
    input string                 field,
    input logic signed [63:0]    want,
    input logic signed [63:0]    got
  );
    fit_errors++;
    $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
  endtask

  // Compare one result beat against the oldest pending fit
  task automatic check_result();
    line_fit_t want;
    if (fit_q.size() == 0) begin
      fit_errors++;
      $display("%0t ns: result beat with no fit pending, expected none, actual slope %0d",
               $time, out_mon.slope);
      return;
    end
    want = fit_q.pop_front();
    if (out_mon.slope !== want.slope)
      flag_field("slope", want.slope, out_mon.slope);
    if (out_mon.intercept !== want.intercept)
      flag_field("intercept", want.intercept, out_mon.intercept);
    if (out_mon.status !== want.status)
      flag_field("status", want.status, out_mon.status);
    if (out_mon.points_used !== want.points_used)
      flag_field("points_used", want.points_used, out_mon.points_used);
    if (out_mon.truncated !== want.truncated)
      flag_field("truncated", want.truncated, out_mon.truncated);
  endtask

  // Check the result beat before taking a point of the same edge
  always @(posedge clk) begin
    if (!rst_n) begin
      clear_sums();
      fit_q.delete();
      fit_errors = 0;
    end else begin
      if (out_mon.valid && out_mon.ready) check_result();
      if (in_mon.valid && in_mon.ready)
        take_point(in_mon.x_value, in_mon.y_value, in_mon.last_point);
    end
    fits_pending = fit_q.size();
  end

endmodule

FILE: sim/tb_linear_least_squares_fit.sv
// Top of the line-fit testbench: clock, reset, point stimulus, result pacing and verdict.
module tb_linear_least_squares_fit;
  timeunit 1ns;
  timeprecision 1ps;
  import llsf_pkg::*;

  localparam int TOTAL_POINTS = 1450;
  localparam int IDLE_PCT     = 36;
  localparam int HOLD_CYCLES  = 800;
  localparam int QUIET_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 300;
  localparam int STEADY_FROM  = 1180;
  localparam int STEADY_TO    = 1320;

  typedef enum int {
    SPREAD_FULL,
    SPREAD_NARROW,
    X_CONSTANT,
    ON_A_LINE,
    EDGE_ONLY
  } set_shape_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  bit   gaps_on = 1'b1;
  int   hold_asks = 0;
  int   points_sent = 0;
  int   quiet_cycles = 0;
  int   fit_errors;
  int   fits_pending;

  always #10 clk = ~clk;

  llsf_in_if  in_ch ();
  llsf_out_if out_ch ();

  linear_least_squares_fit uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  llsf_fit_checker fit_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_mon       (in_ch),
    .out_mon      (out_ch),
    .fit_errors   (fit_errors),
    .fits_pending (fits_pending)
  );

  // Offer one point, idle first at random, return at the falling edge after the beat
  task automatic send_point(input int xv, input int yv, input bit last);
    while (gaps_on && $urandom_range(0, 99) < IDLE_PCT) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid      = 1'b1;
    in_ch.x_value    = xv[FIELD_W-1:0];
    in_ch.y_value    = yv[FIELD_W-1:0];
    in_ch.last_point = last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    points_sent++;
    @(negedge clk);
  endtask

  // Send one data set of the given size and shape, last point marked
  task automatic send_set(input int size, input set_shape_t shape);
    int xv, yv, k, b, x_fixed;
    k       = $urandom_range(0, 20);
    k       = k - 10;
    b       = $urandom_range(0, 200);
    b       = b - 100;
    x_fixed = $urandom_range(0, 65535);
    x_fixed = x_fixed - 32768;
    for (int i = 0; i < size; i++) begin
      xv = $urandom_range(0, 65535);
      yv = $urandom_range(0, 65535);
      case (shape)
        SPREAD_NARROW: begin
          xv = (xv % 41) - 20;
          yv = (yv % 41) - 20;
        end
        X_CONSTANT: begin
          xv = x_fixed;
        end
        ON_A_LINE: begin
          xv = (xv % 201) - 100;
          yv = k * xv + b;
        end
        EDGE_ONLY: begin
          xv = (xv % 2) ? 32767 : -32768;
          yv = (yv % 3 == 0) ? 0 : ((yv % 3 == 1) ? 32767 : -32768);
        end
        default: begin
        end
      endcase
      send_point(xv, yv, i == size - 1);
    end
  endtask

  // Pace the result side; each hold request freezes it for a counted stretch
  initial begin
    int holds_done;
    holds_done   = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_asks != holds_done) begin
        out_ch.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        holds_done++;
      end
      out_ch.ready = !gaps_on || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // Watchdog: end the run when no beat moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int         r;
    int         size;
    set_shape_t shape;
    in_ch.valid      = 1'b0;
    in_ch.x_value    = '0;
    in_ch.y_value    = '0;
    in_ch.last_point = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Too few points: one, then two, mostly at the sample extremes
    send_point(-32768, 32767, 1'b1);
    send_point(32767, -32768, 1'b0);
    send_point(0, 0, 1'b1);
    // All x equal gives a zero denominator
    send_point(5, 1, 1'b0);
    send_point(5, 2, 1'b0);
    send_point(5, -3, 1'b1);
    // Corner samples only
    send_point(-32768, -32768, 1'b0);
    send_point(32767, 32767, 1'b0);
    send_point(-32768, 32767, 1'b0);
    send_point(32767, -32768, 1'b1);
    // Exact line y = 2x + 1
    send_point(0, 1, 1'b0);
    send_point(1, 3, 1'b0);
    send_point(2, 5, 1'b0);
    send_point(3, 7, 1'b1);
    // Falling line through the origin
    send_point(1, -1, 1'b0);
    send_point(0, 0, 1'b0);
    send_point(-1, 1, 1'b1);
    // Scattered points whose fit has slope 1 and intercept 0
    send_point(-1, 0, 1'b0);
    send_point(0, -1, 1'b0);
    send_point(1, 0, 1'b0);
    send_point(2, 3, 1'b1);

    // Overfill capacity; the last point is itself dropped yet still closes the set
    send_set(MAX_POINTS + 2, SPREAD_FULL);

    // Freeze results while points keep coming, so the input backs up
    gaps_on = 1'b0;
    hold_asks++;
    repeat (8) send_set(3, SPREAD_FULL);
    gaps_on = 1'b1;
    in_ch.valid = 1'b0;
    while (fits_pending != 0) @(negedge clk);

    // Random data sets, mostly small, with one stretch free of idling
    while (points_sent < TOTAL_POINTS) begin
      gaps_on = !(points_sent >= STEADY_FROM && points_sent < STEADY_TO);
      r = $urandom_range(0, 99);
      if (r < 70)      size = $urandom_range(1, 6);
      else if (r < 95) size = $urandom_range(7, 20);
      else             size = $urandom_range(21, 60);
      shape = set_shape_t'($urandom_range(0, 4));
      send_set(size, shape);
    end
    gaps_on     = 1'b1;
    in_ch.valid = 1'b0;

    // Drain every pending fit, then watch for stray beats
    while (fits_pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fit_errors == 0 && fits_pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
